### sv/gnt_pkg.sv
// Shared constants, command codes, state encoding and types for the gradient noise block.
`timescale 1ns / 1ps

package gnt_pkg;

	// Fixed field widths of the channels and the register port
	localparam int CMD_W      = 3;
	localparam int TIDX_W     = 8;
	localparam int PERM_W     = 8;
	localparam int GRAD_IN_W  = 16;
	localparam int POS_W      = 32;
	localparam int NOISE_W    = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int OCT_W      = 4;

	// Command codes; codes above CMD_QUERY are ignored
	localparam logic [CMD_W-1:0] CMD_WR_X    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_Y    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WR_Z    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WR_GRAD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TURB_MODE    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_ISSUE,
		ST_DRAIN,
		ST_OCTAVE,
		ST_DONE
	} state_t;

	// One lattice corner travelling down the read and multiply pipeline
	typedef struct packed {
		logic       valid;
		logic [2:0] corner;
	} corner_tag_t;

	// Table write request taken from an accepted write item
	typedef struct packed {
		logic                        en;
		logic [CMD_W-1:0]            cmd;
		logic [TIDX_W-1:0]           index;
		logic [PERM_W-1:0]           perm;
		logic signed [GRAD_IN_W-1:0] gx;
		logic signed [GRAD_IN_W-1:0] gy;
		logic signed [GRAD_IN_W-1:0] gz;
	} tbl_wr_t;

endpackage

### sv/gnt_if.sv
// Valid/ready channel interfaces for command items and noise result items.
`timescale 1ns / 1ps

interface gnt_cmd_if;
	import gnt_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            cmd;
	logic [TIDX_W-1:0]           table_index;
	logic [PERM_W-1:0]           perm_value;
	logic signed [GRAD_IN_W-1:0] grad_x;
	logic signed [GRAD_IN_W-1:0] grad_y;
	logic signed [GRAD_IN_W-1:0] grad_z;
	logic signed [POS_W-1:0]     pos_x;
	logic signed [POS_W-1:0]     pos_y;
	logic signed [POS_W-1:0]     pos_z;

	modport source (
		output valid, cmd, table_index, perm_value, grad_x, grad_y, grad_z,
		output pos_x, pos_y, pos_z,
		input  ready
	);
	modport sink (
		input  valid, cmd, table_index, perm_value, grad_x, grad_y, grad_z,
		input  pos_x, pos_y, pos_z,
		output ready
	);
endinterface

interface gnt_noise_if;
	import gnt_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [NOISE_W-1:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

### sv/gnt_tables.sv
// Permutation and gradient memories with the two-step hashed corner lookup.
`timescale 1ns / 1ps

module gnt_tables #(
	parameter int TABLE_SIZE = 256,
	parameter int GRAD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gnt_pkg::tbl_wr_t              wr,
	input  gnt_pkg::corner_tag_t          rd_tag,
	input  logic [$clog2(TABLE_SIZE)-1:0] lat_idx [3],
	output gnt_pkg::corner_tag_t          tag_s2,
	output logic signed [GRAD_WIDTH-1:0]  grad_x,
	output logic signed [GRAD_WIDTH-1:0]  grad_y,
	output logic signed [GRAD_WIDTH-1:0]  grad_z,
	output logic                          busy
);
	import gnt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);

	logic [IDX_W-1:0]        xperm_mem [TABLE_SIZE];
	logic [IDX_W-1:0]        yperm_mem [TABLE_SIZE];
	logic [IDX_W-1:0]        zperm_mem [TABLE_SIZE];
	logic [3*GRAD_WIDTH-1:0] grad_mem  [TABLE_SIZE];

	logic [IDX_W-1:0]        wr_idx, wr_perm;
	logic [3*GRAD_WIDTH-1:0] wr_grad;
	logic [IDX_W-1:0]        addr_x, addr_y, addr_z, hash;
	logic [IDX_W-1:0]        xp_s1, yp_s1, zp_s1;
	logic [3*GRAD_WIDTH-1:0] grad_s2;
	corner_tag_t             tag_s1;

	always_comb begin
		wr_idx  = IDX_W'(wr.index);
		wr_perm = IDX_W'(wr.perm);
		wr_grad = {GRAD_WIDTH'(wr.gz), GRAD_WIDTH'(wr.gy), GRAD_WIDTH'(wr.gx)};
		// The upper corner along an axis is the next cell, wrapping round the table
		addr_x  = lat_idx[0] + IDX_W'(rd_tag.corner[2]);
		addr_y  = lat_idx[1] + IDX_W'(rd_tag.corner[1]);
		addr_z  = lat_idx[2] + IDX_W'(rd_tag.corner[0]);
		hash    = xp_s1 ^ yp_s1 ^ zp_s1;
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.cmd == CMD_WR_X) begin
			xperm_mem[wr_idx] <= wr_perm;
		end
		if (wr.en && wr.cmd == CMD_WR_Y) begin
			yperm_mem[wr_idx] <= wr_perm;
		end
		if (wr.en && wr.cmd == CMD_WR_Z) begin
			zperm_mem[wr_idx] <= wr_perm;
		end
		if (wr.en && wr.cmd == CMD_WR_GRAD) begin
			grad_mem[wr_idx] <= wr_grad;
		end
		xp_s1   <= xperm_mem[addr_x];
		yp_s1   <= yperm_mem[addr_y];
		zp_s1   <= zperm_mem[addr_z];
		grad_s2 <= grad_mem[hash];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= rd_tag;
			tag_s2 <= tag_s1;
		end
	end

	assign grad_x = signed'(grad_s2[GRAD_WIDTH-1:0]);
	assign grad_y = signed'(grad_s2[2*GRAD_WIDTH-1:GRAD_WIDTH]);
	assign grad_z = signed'(grad_s2[3*GRAD_WIDTH-1:2*GRAD_WIDTH]);
	assign busy   = tag_s1.valid | tag_s2.valid;

endmodule

### sv/gnt_smooth.sv
// Smoothstep weights for the three axes, computed on one shared multiplier.
`timescale 1ns / 1ps

module gnt_smooth #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FRAC_BITS-1:0] t [3],
	output logic [FRAC_BITS:0]   sw [3],
	output logic                 done
);
	localparam logic [FRAC_BITS+1:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};
	localparam logic [1:0]           AXIS_LAST = 2'd2;

	logic                   busy_q, phase_q, done_q;
	logic [1:0]             axis_q;
	logic [FRAC_BITS-1:0]   t2_q;
	logic [FRAC_BITS:0]     sw_q [3];
	logic [FRAC_BITS-1:0]   t_cur;
	logic [FRAC_BITS+1:0]   op_a, op_b;
	logic [2*FRAC_BITS+3:0] prod;

	// First pass squares t, second pass multiplies t^2 by (3 - 2t)
	always_comb begin
		t_cur = t[axis_q];
		op_a  = phase_q ? {2'b00, t2_q} : {2'b00, t_cur};
		op_b  = phase_q ? THREE_ONE - {1'b0, t_cur, 1'b0} : {2'b00, t_cur};
		prod  = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			axis_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				axis_q  <= '0;
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (axis_q == AXIS_LAST) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !phase_q) begin
			t2_q <= prod[2*FRAC_BITS-1:FRAC_BITS];
		end
		if (busy_q && phase_q) begin
			sw_q[axis_q] <= prod[2*FRAC_BITS:FRAC_BITS];
		end
	end

	assign sw   = sw_q;
	assign done = done_q;

endmodule

### sv/gnt_corner_unit.sv
// Corner datapath: gradient dot product, trilinear weight and corner accumulation.
`timescale 1ns / 1ps

module gnt_corner_unit #(
	parameter int FRAC_BITS  = 16,
	parameter int GRAD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gnt_pkg::corner_tag_t                tag_s2,
	input  logic signed [GRAD_WIDTH-1:0]        grad_x,
	input  logic signed [GRAD_WIDTH-1:0]        grad_y,
	input  logic signed [GRAD_WIDTH-1:0]        grad_z,
	input  logic [FRAC_BITS-1:0]                frac [3],
	input  logic [FRAC_BITS:0]                  sw [3],
	input  logic                                acc_clr,
	output logic signed [2*FRAC_BITS+5:0]       acc,
	output logic                                busy
);
	import gnt_pkg::*;

	localparam int PW = GRAD_WIDTH + FRAC_BITS + 1; // one gradient product
	localparam int DW = FRAC_BITS + 3;              // dot product after scaling
	localparam int MW = 2 * FRAC_BITS + 5;          // weight times dot
	localparam int AW = 2 * FRAC_BITS + 6;          // sum over eight corners
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic                     di, dj, dk;
	logic signed [FRAC_BITS:0] du, dv, dw;
	logic [FRAC_BITS:0]       wx, wy;
	logic [2*FRAC_BITS+1:0]   wxy_prod, w_prod;
	logic signed [PW+1:0]     dot_sum;
	logic signed [PW+1:0]     dot_shift;

	logic signed [PW-1:0]     px_s3, py_s3, pz_s3;
	logic [FRAC_BITS:0]       wxy_s3, wz_s3;
	logic signed [DW-1:0]     dot_s4;
	logic [FRAC_BITS:0]       w_s4;
	logic signed [MW-1:0]     prod_s5;
	logic                     v_s3, v_s4, v_s5;
	logic signed [AW-1:0]     acc_q;

	always_comb begin
		di = tag_s2.corner[2];
		dj = tag_s2.corner[1];
		dk = tag_s2.corner[0];
		// The offset from the upper corner is t - 1, which is t with the sign bit set
		du = signed'({di, frac[0]});
		dv = signed'({dj, frac[1]});
		dw = signed'({dk, frac[2]});
		wx = di ? sw[0] : ONE - sw[0];
		wy = dj ? sw[1] : ONE - sw[1];
		wxy_prod  = wx * wy;
		dot_sum   = (PW+2)'(px_s3) + (PW+2)'(py_s3) + (PW+2)'(pz_s3);
		dot_shift = dot_sum >>> (GRAD_WIDTH - 1);
		w_prod    = wxy_s3 * wz_s3;
	end

	always_ff @(posedge clk) begin
		px_s3   <= grad_x * du;
		py_s3   <= grad_y * dv;
		pz_s3   <= grad_z * dw;
		wxy_s3  <= wxy_prod[2*FRAC_BITS:FRAC_BITS];
		wz_s3   <= dk ? sw[2] : ONE - sw[2];
		dot_s4  <= DW'(dot_shift);
		w_s4    <= w_prod[2*FRAC_BITS:FRAC_BITS];
		prod_s5 <= signed'({1'b0, w_s4}) * dot_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s3 <= tag_s2.valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (acc_clr) begin
				acc_q <= '0;
			end else if (v_s5) begin
				acc_q <= acc_q + AW'(prod_s5);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = v_s3 | v_s4 | v_s5;

endmodule

### sv/gradient_noise_turbulence_unit.sv
// Top level of the 3D gradient noise and turbulence block.
// A table write item does not leave the idle state, so the next item can follow straight away.
// A query runs each octave through the smoothstep multiplier, eight corner issues, a drain
// of the corner pipeline and a fold of the octave, then loads the result for output.
// arst_n resets the sequencer and the configuration registers; the tables hold nothing until written.
`timescale 1ns / 1ps

module gradient_noise_turbulence_unit #(
	parameter int TABLE_SIZE  = 256,
	parameter int FRAC_BITS   = 16,
	parameter int GRAD_WIDTH  = 16,
	parameter int MAX_OCTAVES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	gnt_cmd_if.sink                          cmd_ch,
	gnt_noise_if.source                      noise_ch,
	input  logic                             cfg_we,
	input  logic [gnt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gnt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gnt_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_SIZE);
	localparam int PW        = FRAC_BITS + IDX_W;
	localparam int AW        = 2 * FRAC_BITS + 6;
	localparam int NW        = AW - FRAC_BITS;
	localparam int TW        = FRAC_BITS + 8;
	localparam int EW        = (TW > NOISE_W + 1) ? TW : NOISE_W + 1;
	localparam int CNT_MIN_W = $clog2(MAX_OCTAVES + 1);
	localparam int CNT_W     = (CNT_MIN_W > OCT_W) ? CNT_MIN_W : OCT_W;
	localparam logic [2:0] CORNER_LAST = 3'd7;

	state_t               state_q, state_d;
	logic [OCT_W-1:0]     octave_count_q;
	logic                 turb_q;
	logic [PW-1:0]        pos_q [3];
	logic [CNT_W-1:0]     oct_q, noct_q, noct_d;
	logic [2:0]           corner_q;
	logic signed [TW-1:0] total_q;
	logic                 out_valid_q;
	logic [NOISE_W-1:0]   out_data_q;

	logic                 accept, query_go, smooth_start, issue, acc_clr, oct_step, load_out;
	logic                 last_oct, smooth_done, tbl_busy, cu_busy;
	logic [FRAC_BITS-1:0] frac [3];
	logic [IDX_W-1:0]     lat_idx [3];
	logic [FRAC_BITS:0]   sw [3];
	logic [CNT_W-1:0]     oc_ext;
	tbl_wr_t              wr;
	corner_tag_t          rd_tag, tag_s2;
	logic signed [GRAD_WIDTH-1:0] grad_x, grad_y, grad_z;
	logic signed [AW-1:0] cu_acc;
	logic signed [NW-1:0] noise, contrib;
	logic signed [TW-1:0] mag;
	logic signed [EW-1:0] mag_ext;
	logic [NOISE_W-1:0]   sat;

	assign accept       = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (state_q == ST_IDLE);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			frac[a]    = pos_q[a][FRAC_BITS-1:0];
			lat_idx[a] = pos_q[a][PW-1:FRAC_BITS];
		end
	end

	always_comb begin
		wr.en    = accept;
		wr.cmd   = cmd_ch.cmd;
		wr.index = cmd_ch.table_index;
		wr.perm  = cmd_ch.perm_value;
		wr.gx    = cmd_ch.grad_x;
		wr.gy    = cmd_ch.grad_y;
		wr.gz    = cmd_ch.grad_z;
		rd_tag.valid  = issue;
		rd_tag.corner = corner_q;
	end

	// Plain mode always runs a single octave; turbulence clamps the count into range
	always_comb begin
		oc_ext = CNT_W'(octave_count_q);
		if (!turb_q || oc_ext == '0) begin
			noct_d = CNT_W'(1);
		end else if (oc_ext > CNT_W'(MAX_OCTAVES)) begin
			noct_d = CNT_W'(MAX_OCTAVES);
		end else begin
			noct_d = oc_ext;
		end
	end

	always_comb begin
		last_oct = (oct_q + CNT_W'(1)) == noct_q;
		noise    = NW'(cu_acc >>> FRAC_BITS);
		contrib  = noise >>> oct_q;
		mag      = (turb_q && total_q < 0) ? -total_q : total_q;
		mag_ext  = EW'(mag);
		if (mag_ext[EW-1:NOISE_W-1] == '0 || mag_ext[EW-1:NOISE_W-1] == '1) begin
			sat = mag_ext[NOISE_W-1:0];
		end else if (mag_ext[EW-1]) begin
			sat = {1'b1, {(NOISE_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(NOISE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		query_go     = 1'b0;
		smooth_start = 1'b0;
		issue        = 1'b0;
		acc_clr      = 1'b0;
		oct_step     = 1'b0;
		load_out     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_ch.cmd == CMD_QUERY) begin
					query_go     = 1'b1;
					smooth_start = 1'b1;
					acc_clr      = 1'b1;
					state_d      = ST_SMOOTH;
				end
			end
			ST_SMOOTH: begin
				if (smooth_done) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (corner_q == CORNER_LAST) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!tbl_busy && !cu_busy) begin
					state_d = ST_OCTAVE;
				end
			end
			ST_OCTAVE: begin
				oct_step = 1'b1;
				acc_clr  = 1'b1;
				if (last_oct) begin
					state_d = ST_DONE;
				end else begin
					smooth_start = 1'b1;
					state_d      = ST_SMOOTH;
				end
			end
			ST_DONE: begin
				// Wait here only while an earlier result is still not taken
				if (!out_valid_q || noise_ch.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCT_W'(1);
			turb_q         <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[OCT_W-1:0];
				REG_TURB_MODE:    turb_q         <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q    <= '0;
			oct_q       <= '0;
			noct_q      <= CNT_W'(1);
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				corner_q <= corner_q + 3'd1;
			end
			if (query_go) begin
				oct_q   <= '0;
				noct_q  <= noct_d;
				total_q <= '0;
			end else if (oct_step) begin
				oct_q   <= oct_q + CNT_W'(1);
				total_q <= total_q + TW'(contrib);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (noise_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Each octave doubles the position; only the cell and fraction bits are kept
	always_ff @(posedge clk) begin
		if (query_go) begin
			pos_q[0] <= PW'(cmd_ch.pos_x);
			pos_q[1] <= PW'(cmd_ch.pos_y);
			pos_q[2] <= PW'(cmd_ch.pos_z);
		end else if (oct_step) begin
			for (int a = 0; a < 3; a++) begin
				pos_q[a] <= pos_q[a] << 1;
			end
		end
		if (load_out) begin
			out_data_q <= sat;
		end
	end

	assign noise_ch.valid       = out_valid_q;
	assign noise_ch.noise_value = signed'(out_data_q);

	gnt_tables #(
		.TABLE_SIZE (TABLE_SIZE),
		.GRAD_WIDTH (GRAD_WIDTH)
	) u_tables (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_tag  (rd_tag),
		.lat_idx (lat_idx),
		.tag_s2  (tag_s2),
		.grad_x  (grad_x),
		.grad_y  (grad_y),
		.grad_z  (grad_z),
		.busy    (tbl_busy)
	);

	gnt_smooth #(
		.FRAC_BITS (FRAC_BITS)
	) u_smooth (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (smooth_start),
		.t      (frac),
		.sw     (sw),
		.done   (smooth_done)
	);

	gnt_corner_unit #(
		.FRAC_BITS  (FRAC_BITS),
		.GRAD_WIDTH (GRAD_WIDTH)
	) u_corner (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s2  (tag_s2),
		.grad_x  (grad_x),
		.grad_y  (grad_y),
		.grad_z  (grad_z),
		.frac    (frac),
		.sw      (sw),
		.acc_clr (acc_clr),
		.acc     (cu_acc),
		.busy    (cu_busy)
	);

	a_corner_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ISSUE |-> corner_q == 3'd0)
		else $error("corner counter not at zero outside the issue phase");

	a_octave_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OCTAVE |-> !tbl_busy && !cu_busy)
		else $error("octave folded while corners are still in flight");

	a_octaves_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && $past(state_q) == ST_OCTAVE |-> oct_q == noct_q)
		else $error("result produced before every octave was summed");

	a_plain_single: assert property (@(posedge clk) disable iff (!arst_n)
		query_go && !turb_q |=> noct_q == CNT_W'(1))
		else $error("plain noise query set up for more than one octave");

endmodule

### tb/gradient_noise_turbulence_unit_tb.sv
// Self-checking testbench for the gradient noise and turbulence block, with its own predictor.
`timescale 1ns / 1ps

module gradient_noise_turbulence_unit_tb;
	import gnt_pkg::*;

	localparam int     FRAC          = 16;
	localparam int     GRAD_SHIFT    = 15;
	localparam int     MAX_OCT       = 8;
	localparam longint ONE_FX        = longint'(1) << FRAC;
	localparam int     SETTLE_CYCLES = 200;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     STALL_LIMIT   = 4000;
	localparam int     PHASE_ITEMS   = 142;

	typedef enum int {
		PACE_SRC_LIGHT,
		PACE_SRC_HEAVY,
		PACE_FREE
	} pace_t;

	typedef struct packed {
		logic [CMD_W-1:0]            cmd;
		logic [TIDX_W-1:0]           table_index;
		logic [PERM_W-1:0]           perm_value;
		logic signed [GRAD_IN_W-1:0] grad_x;
		logic signed [GRAD_IN_W-1:0] grad_y;
		logic signed [GRAD_IN_W-1:0] grad_z;
		logic signed [POS_W-1:0]     pos_x;
		logic signed [POS_W-1:0]     pos_y;
		logic signed [POS_W-1:0]     pos_z;
	} noise_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic drv_valid = 1'b0;
	noise_cmd_t drv_item = '0;
	logic drv_ready = 1'b0;

	gnt_cmd_if   cmd_ch ();
	gnt_noise_if noise_ch ();

	assign cmd_ch.valid       = drv_valid;
	assign cmd_ch.cmd         = drv_item.cmd;
	assign cmd_ch.table_index = drv_item.table_index;
	assign cmd_ch.perm_value  = drv_item.perm_value;
	assign cmd_ch.grad_x      = drv_item.grad_x;
	assign cmd_ch.grad_y      = drv_item.grad_y;
	assign cmd_ch.grad_z      = drv_item.grad_z;
	assign cmd_ch.pos_x       = drv_item.pos_x;
	assign cmd_ch.pos_y       = drv_item.pos_y;
	assign cmd_ch.pos_z       = drv_item.pos_z;
	assign noise_ch.ready     = drv_ready;

	gradient_noise_turbulence_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.noise_ch  (noise_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state: the tables and a copy of the registers.
	logic [7:0]                  xperm_tbl [256];
	logic [7:0]                  yperm_tbl [256];
	logic [7:0]                  zperm_tbl [256];
	logic signed [GRAD_IN_W-1:0] grad_tbl_x [256];
	logic signed [GRAD_IN_W-1:0] grad_tbl_y [256];
	logic signed [GRAD_IN_W-1:0] grad_tbl_z [256];
	logic [OCT_W-1:0]            oct_cfg = 4'd1;
	logic                        turb_cfg = 1'b0;

	noise_cmd_t        pending_cmds [$];
	logic signed [31:0] expected_noise [$];
	pace_t             pace = PACE_SRC_LIGHT;
	logic              cmd_taken = 1'b0;
	logic              hold_req = 1'b0;
	logic              hold_done = 1'b0;
	int                hold_left = 0;
	int                stall_cycles = 0;
	int                errors = 0;

	function automatic longint smoothstep_fx(longint t);
		longint t2;
		t2 = (t * t) >>> FRAC;
		return (t2 * (3 * ONE_FX - 2 * t)) >>> FRAC;
	endfunction

	// Gradient noise of one octave; the positions are already scaled for that octave.
	function automatic longint lattice_noise(logic [63:0] qx, logic [63:0] qy, logic [63:0] qz);
		logic [7:0] cx, cy, cz, ia, ib, ic, h;
		longint fx, fy, fz, sx, sy, sz;
		longint gx, gy, gz, du, dv, dw, dot, wx, wy, wz, w, acc;
		logic di, dj, dk;
		cx = qx[23:16];
		cy = qy[23:16];
		cz = qz[23:16];
		fx = longint'(qx[15:0]);
		fy = longint'(qy[15:0]);
		fz = longint'(qz[15:0]);
		sx = smoothstep_fx(fx);
		sy = smoothstep_fx(fy);
		sz = smoothstep_fx(fz);
		acc = 0;
		for (int c = 0; c < 8; c++) begin
			di = c[2];
			dj = c[1];
			dk = c[0];
			ia = cx + {7'd0, di};
			ib = cy + {7'd0, dj};
			ic = cz + {7'd0, dk};
			h = xperm_tbl[ia] ^ yperm_tbl[ib] ^ zperm_tbl[ic];
			gx = longint'(grad_tbl_x[h]);
			gy = longint'(grad_tbl_y[h]);
			gz = longint'(grad_tbl_z[h]);
			du = fx - (di ? ONE_FX : 0);
			dv = fy - (dj ? ONE_FX : 0);
			dw = fz - (dk ? ONE_FX : 0);
			dot = (gx * du + gy * dv + gz * dw) >>> GRAD_SHIFT;
			wx = di ? sx : ONE_FX - sx;
			wy = dj ? sy : ONE_FX - sy;
			wz = dk ? sz : ONE_FX - sz;
			w = (((wx * wy) >>> FRAC) * wz) >>> FRAC;
			acc += w * dot;
		end
		return acc >>> FRAC;
	endfunction

	function automatic logic signed [31:0] predict_noise(noise_cmd_t it);
		longint bx, by, bz, acc;
		int octs;
		bx = longint'(it.pos_x);
		by = longint'(it.pos_y);
		bz = longint'(it.pos_z);
		octs = 1;
		if (turb_cfg) begin
			octs = int'(oct_cfg);
			if (octs < 1)
				octs = 1;
			if (octs > MAX_OCT)
				octs = MAX_OCT;
		end
		acc = 0;
		for (int o = 0; o < octs; o++)
			acc += lattice_noise(bx << o, by << o, bz << o) >>> o;
		if (turb_cfg && acc < 0)
			acc = -acc;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return acc[31:0];
	endfunction

	function automatic int send_idle_pct();
		case (pace)
			PACE_SRC_LIGHT: return 24;
			PACE_SRC_HEAVY: return 53;
			default:        return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (pace)
			PACE_SRC_LIGHT: return 53;
			PACE_SRC_HEAVY: return 24;
			default:        return 0;
		endcase
	endfunction

	// Driver: a new item is offered at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		if (!drv_valid || cmd_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
				drv_item <= pending_cmds.pop_front();
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that lets the block back up.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			drv_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			drv_ready <= 1'b0;
		end else begin
			drv_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
		end
	end

	// Monitor: results are checked before the item taken at the same edge is predicted.
	always @(posedge clk) begin
		logic signed [31:0] want;
		logic               busy;
		busy = 1'b0;
		if (arst_n && noise_ch.valid === 1'b1 && noise_ch.ready) begin
			busy = 1'b1;
			if (expected_noise.size() == 0) begin
				$display("%0t: unexpected noise item, expected none, actual %0d",
					$time, noise_ch.noise_value);
				errors++;
			end else begin
				want = expected_noise.pop_front();
				if (noise_ch.noise_value !== want) begin
					$display("%0t: noise_value mismatch, expected %0d, actual %0d",
						$time, want, noise_ch.noise_value);
					errors++;
				end
			end
		end
		cmd_taken = arst_n && drv_valid && cmd_ch.ready === 1'b1;
		if (cmd_taken) begin
			busy = 1'b1;
			case (drv_item.cmd)
				CMD_WR_X: xperm_tbl[drv_item.table_index] = drv_item.perm_value;
				CMD_WR_Y: yperm_tbl[drv_item.table_index] = drv_item.perm_value;
				CMD_WR_Z: zperm_tbl[drv_item.table_index] = drv_item.perm_value;
				CMD_WR_GRAD: begin
					grad_tbl_x[drv_item.table_index] = drv_item.grad_x;
					grad_tbl_y[drv_item.table_index] = drv_item.grad_y;
					grad_tbl_z[drv_item.table_index] = drv_item.grad_z;
				end
				CMD_QUERY: expected_noise.push_back(predict_noise(drv_item));
				default: ;
			endcase
		end
		stall_cycles = busy ? 0 : stall_cycles + 1;
	end

	function automatic noise_cmd_t random_item(logic [CMD_W-1:0] code);
		noise_cmd_t it;
		it.cmd         = code;
		it.table_index = TIDX_W'($urandom);
		it.perm_value  = PERM_W'($urandom);
		it.grad_x      = GRAD_IN_W'($urandom);
		it.grad_y      = GRAD_IN_W'($urandom);
		it.grad_z      = GRAD_IN_W'($urandom);
		it.pos_x       = $urandom;
		it.pos_y       = $urandom;
		it.pos_z       = $urandom;
		return it;
	endfunction

	// Positions are biased towards cell edges and the origin now and then.
	function automatic logic [31:0] random_pos();
		logic [31:0] p;
		p = $urandom;
		case ($urandom_range(0, 9))
			0: p[15:0] = 16'h0000;
			1: p[15:0] = 16'hFFFF;
			2: p = $urandom_range(0, 32'h3FFFF) - 32'h20000;
			default: ;
		endcase
		return p;
	endfunction

	task automatic push_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		noise_cmd_t it;
		it = random_item(CMD_QUERY);
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		pending_cmds.push_back(it);
	endtask

	task automatic push_table_write(logic [CMD_W-1:0] code, logic [7:0] idx, logic [7:0] val,
		logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
		noise_cmd_t it;
		it = random_item(code);
		it.table_index = idx;
		it.perm_value  = val;
		it.grad_x      = gx;
		it.grad_y      = gy;
		it.grad_z      = gz;
		pending_cmds.push_back(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		if (idx == REG_OCTAVE_COUNT)
			oct_cfg = val;
		else
			turb_cfg = val[0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// The sender holds back until every expected item has come and the block has settled.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || drv_valid || expected_noise.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [CMD_W-1:0] write_codes [4];
		noise_cmd_t       it;
		int               r;
		write_codes = '{CMD_WR_X, CMD_WR_Y, CMD_WR_Z, CMD_WR_GRAD};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_reg(REG_OCTAVE_COUNT, 4'd1);
		write_reg(REG_TURB_MODE, 4'd0);

		// Every entry of every table is loaded before the first query.
		for (int i = 0; i < 256; i++) begin
			push_table_write(CMD_WR_X, 8'(i), 8'($urandom), 16'd0, 16'd0, 16'd0);
			push_table_write(CMD_WR_Y, 8'(i), 8'($urandom), 16'd0, 16'd0, 16'd0);
			push_table_write(CMD_WR_Z, 8'(i), 8'($urandom), 16'd0, 16'd0, 16'd0);
			if (i == 0)
				push_table_write(CMD_WR_GRAD, 8'(i), 8'd0, 16'h8000, 16'h8000, 16'h8000);
			else if (i == 255)
				push_table_write(CMD_WR_GRAD, 8'(i), 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
			else
				push_table_write(CMD_WR_GRAD, 8'(i), 8'd0, 16'($urandom), 16'($urandom),
					16'($urandom));
		end

		// Plain noise at the corners of the position range, unused codes and table extremes.
		push_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_query(32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_8000);
		push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		pending_cmds.push_back(random_item(CMD_QUERY + 3'd1));
		pending_cmds.push_back(random_item(CMD_QUERY + 3'd2));
		pending_cmds.push_back(random_item(CMD_QUERY + 3'd3));
		push_table_write(CMD_WR_X, 8'd0, 8'd255, 16'd0, 16'd0, 16'd0);
		push_table_write(CMD_WR_Y, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0);
		push_table_write(CMD_WR_Z, 8'd128, 8'd255, 16'd0, 16'd0, 16'd0);
		push_table_write(CMD_WR_GRAD, 8'd1, 8'd0, 16'h7FFF, 16'h8000, 16'h0000);
		push_query(32'h00FF_FFFF, 32'hFF00_0001, 32'h0080_0000);
		push_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		wait_drained();

		// Octave count above the maximum is clamped.
		write_reg(REG_TURB_MODE, 4'd1);
		write_reg(REG_OCTAVE_COUNT, 4'd15);
		push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_query(random_pos(), random_pos(), random_pos());
		wait_drained();

		// An octave count of zero behaves as one.
		write_reg(REG_OCTAVE_COUNT, 4'd0);
		push_query(random_pos(), random_pos(), random_pos());
		push_query(32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_0000);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_TURB_MODE, 4'd0); write_reg(REG_OCTAVE_COUNT, 4'd15); end
				1: begin write_reg(REG_TURB_MODE, 4'd1); write_reg(REG_OCTAVE_COUNT, 4'd1); end
				2: write_reg(REG_OCTAVE_COUNT, 4'd8);
				3: write_reg(REG_OCTAVE_COUNT, 4'($urandom_range(0, 15)));
				4: write_reg(REG_OCTAVE_COUNT, 4'd2);
				default: begin
					write_reg(REG_TURB_MODE, 4'd0);
					write_reg(REG_OCTAVE_COUNT, 4'd0);
				end
			endcase
			pace = (ph < 2) ? PACE_SRC_LIGHT : (ph < 4) ? PACE_SRC_HEAVY : PACE_FREE;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					push_query(random_pos(), random_pos(), random_pos());
				end else if (r < 90) begin
					it = random_item(write_codes[$urandom_range(0, 3)]);
					pending_cmds.push_back(it);
				end else begin
					pending_cmds.push_back(random_item(CMD_QUERY + 3'($urandom_range(1, 3))));
				end
			end
			// The receiver stops for a long stretch while the sender keeps offering items.
			if (ph == 0)
				hold_req = 1'b1;
			wait_drained();
		end

		if (errors == 0 && expected_noise.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
sv/gnt_pkg.sv
sv/gnt_if.sv
sv/gnt_tables.sv
sv/gnt_smooth.sv
sv/gnt_corner_unit.sv
sv/gradient_noise_turbulence_unit.sv
tb/gradient_noise_turbulence_unit_tb.sv
